// ----- design/ftc_pkg.sv -----
// ----------------------------------------------------------------------------
// ftc_pkg
// Types, codes and helper functions for the Forth token classifier.
// ----------------------------------------------------------------------------
package ftc_pkg;

  localparam int MaxWord     = 256;
  localparam int MaxNest     = 15;
  localparam int LengthLimit = 4095;
  localparam int FifoDepth   = 4;

  typedef logic [20:0] cp_t;
  typedef logic [11:0] len_t;

  typedef struct packed {
    cp_t  code_point;
    logic end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0] token_kind;
    len_t       token_length;
    logic       last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    K_END     = 4'd0,
    K_COMMENT = 4'd1,
    K_DELIM   = 4'd2,
    K_CONTENT = 4'd3,
    K_SEP     = 4'd4,
    K_STRING  = 4'd5,
    K_NUMBER  = 4'd6,
    K_CHAR    = 4'd7,
    K_COLON   = 4'd8,
    K_SEMI    = 4'd9,
    K_WORD    = 4'd10,
    K_ERROR   = 4'd11
  } kind_t;

  typedef enum logic [2:0] {
    MODE_TOP   = 3'd0,
    MODE_LEFT  = 3'd1,
    MODE_RIGHT = 3'd2
  } mode_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_COMMENT = 4'd1,
    PH_WORD    = 4'd2,
    PH_STRING  = 4'd3,
    PH_CONTENT = 4'd4
  } phase_t;

  typedef enum logic [3:0] {
    N_START   = 4'd0,
    N_SIGN    = 4'd1,
    N_HEXNEED = 4'd2,
    N_HEX     = 4'd3,
    N_BINNEED = 4'd4,
    N_BIN     = 4'd5,
    N_OCTNEED = 4'd6,
    N_OCT     = 4'd7,
    N_ZERO    = 4'd8,
    N_INT     = 4'd9,
    N_FRAC    = 4'd10,
    N_EXP     = 4'd11,
    N_EXPSIGN = 4'd12,
    N_EXPDIG  = 4'd13,
    N_REJ     = 4'd14
  } num_t;

  localparam logic [2:0] OpStart = 3'd0;
  localparam logic [2:0] OpDead  = 3'd7;

  typedef struct packed {
    mode_t      mode;
    phase_t     phase;
    len_t       count;
    num_t       num;
    logic [2:0] op;
    logic [3:0] depth;
    logic       dash;
    len_t       spaces;
    logic [7:0] fc0;
    logic [7:0] fc1;
    logic [7:0] fc2;
    logic       ascii;
  } lex_state_t;

  function automatic logic is_ch(cp_t c, logic [7:0] ch);
    return c == {13'd0, ch};
  endfunction

  function automatic logic is_blank(cp_t c);
    return is_ch(c, " ") || is_ch(c, 8'h09) || is_ch(c, 8'h0a) ||
           is_ch(c, 8'h0d) || is_ch(c, 8'h0c) || is_ch(c, 8'h0b);
  endfunction

  function automatic logic is_dec(cp_t c);
    return c >= 21'd48 && c <= 21'd57;
  endfunction

  function automatic logic is_hex(cp_t c);
    return is_dec(c) || (c >= 21'd97 && c <= 21'd102) || (c >= 21'd65 && c <= 21'd70);
  endfunction

  function automatic len_t sat_add(len_t a, logic [12:0] b);
    logic [13:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s > 14'(LengthLimit)) ? len_t'(LengthLimit) : s[11:0];
  endfunction

  function automatic num_t num_body(cp_t c);
    if (is_ch(c, "$")) return N_HEXNEED;
    if (is_ch(c, "%")) return N_BINNEED;
    if (is_ch(c, "&")) return N_OCTNEED;
    if (is_ch(c, "0")) return N_ZERO;
    if (is_dec(c)) return N_INT;
    return N_REJ;
  endfunction

  function automatic num_t num_step(num_t s, cp_t c);
    logic sign;
    logic ex;
    sign = is_ch(c, "+") || is_ch(c, "-");
    ex   = is_ch(c, "e") || is_ch(c, "E");
    case (s)
      N_START: return sign ? N_SIGN : num_body(c);
      N_SIGN: return num_body(c);
      N_HEXNEED, N_HEX: return is_hex(c) ? N_HEX : N_REJ;
      N_BINNEED, N_BIN: return (is_ch(c, "0") || is_ch(c, "1")) ? N_BIN : N_REJ;
      N_OCTNEED, N_OCT: return (c >= 21'd48 && c <= 21'd55) ? N_OCT : N_REJ;
      N_ZERO: begin
        if (is_ch(c, "x") || is_ch(c, "X")) return N_HEXNEED;
        if (is_dec(c)) return N_INT;
        if (is_ch(c, ".")) return N_FRAC;
        return ex ? N_EXP : N_REJ;
      end
      N_INT: begin
        if (is_dec(c)) return N_INT;
        if (is_ch(c, ".")) return N_FRAC;
        return ex ? N_EXP : N_REJ;
      end
      N_FRAC: begin
        if (is_dec(c)) return N_FRAC;
        return ex ? N_EXP : N_REJ;
      end
      N_EXP: begin
        if (sign) return N_EXPSIGN;
        return is_dec(c) ? N_EXPDIG : N_REJ;
      end
      N_EXPSIGN, N_EXPDIG: return is_dec(c) ? N_EXPDIG : N_REJ;
      default: return N_REJ;
    endcase
  endfunction

  function automatic logic num_accepts(num_t s);
    return s == N_ZERO || s == N_INT || s == N_FRAC || s == N_EXPDIG ||
           s == N_HEX || s == N_BIN || s == N_OCT;
  endfunction

  function automatic lex_state_t clear_token(lex_state_t s);
    lex_state_t r;
    r        = s;
    r.phase  = PH_IDLE;
    r.count  = '0;
    r.num    = N_START;
    r.op     = OpStart;
    r.depth  = '0;
    r.dash   = 1'b0;
    r.spaces = '0;
    r.fc0    = '0;
    r.fc1    = '0;
    r.fc2    = '0;
    r.ascii  = 1'b1;
    return r;
  endfunction

endpackage

// ----- design/ftc_lexer.sv -----
// ----------------------------------------------------------------------------
// ftc_lexer
// Tokenizer state and per-character next-state and result logic.
// ----------------------------------------------------------------------------
module ftc_lexer (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  ftc_pkg::in_item_t  item,
  output logic [1:0]         nres,
  output ftc_pkg::out_item_t res0,
  output ftc_pkg::out_item_t res1
);

  ftc_pkg::lex_state_t st;
  ftc_pkg::lex_state_t st_next;
  ftc_pkg::out_item_t  r [2];
  logic [1:0]          k;

  function automatic ftc_pkg::lex_state_t feed_word(ftc_pkg::lex_state_t s,
                                                     ftc_pkg::cp_t c);
    ftc_pkg::lex_state_t n;
    ftc_pkg::cp_t        lc;
    logic [2:0]          op;
    n  = s;
    lc = (c >= 21'd65 && c <= 21'd90) ? (c | 21'd32) : c;
    op = ftc_pkg::OpDead;
    if (c > 21'd127 || s.count >= 12'(ftc_pkg::MaxWord) ||
        s.count >= 12'(ftc_pkg::LengthLimit)) n.ascii = 1'b0;
    if (s.count == 12'd0) n.fc0 = c[7:0];
    if (s.count == 12'd1) n.fc1 = c[7:0];
    if (s.count == 12'd2) n.fc2 = c[7:0];
    n.num   = ftc_pkg::num_step(s.num, c);
    n.count = ftc_pkg::sat_add(s.count, 13'd1);
    if ((s.op == 3'd1 || s.op == 3'd6) && ftc_pkg::is_ch(c, "\"")) begin
      n.op    = ftc_pkg::OpDead;
      n.phase = ftc_pkg::PH_STRING;
    end else begin
      if (s.op == ftc_pkg::OpStart) begin
        if (ftc_pkg::is_ch(c, ".") || ftc_pkg::is_ch(lc, "s") || ftc_pkg::is_ch(lc, "c"))
          op = 3'd1;
        else if (ftc_pkg::is_ch(lc, "a")) op = 3'd2;
      end else if (s.op == 3'd2 && ftc_pkg::is_ch(lc, "b")) op = 3'd3;
      else if (s.op == 3'd3 && ftc_pkg::is_ch(lc, "o")) op = 3'd4;
      else if (s.op == 3'd4 && ftc_pkg::is_ch(lc, "r")) op = 3'd5;
      else if (s.op == 3'd5 && ftc_pkg::is_ch(lc, "t")) op = 3'd6;
      n.op    = op;
      n.phase = ftc_pkg::PH_WORD;
    end
    return n;
  endfunction

  function automatic ftc_pkg::kind_t word_kind(ftc_pkg::lex_state_t s);
    if (s.ascii) begin
      if (s.count == 12'd1 && s.fc0 == ":") return ftc_pkg::K_COLON;
      if (s.count == 12'd1 && s.fc0 == ";") return ftc_pkg::K_SEMI;
      if (s.count == 12'd3 && s.fc0 == "'" && s.fc2 == "'") return ftc_pkg::K_CHAR;
      if (ftc_pkg::num_accepts(s.num)) return ftc_pkg::K_NUMBER;
    end
    return ftc_pkg::K_WORD;
  endfunction

  function automatic ftc_pkg::lex_state_t take_content(ftc_pkg::lex_state_t s);
    ftc_pkg::lex_state_t n;
    n        = s;
    n.count  = ftc_pkg::sat_add(s.count, {1'b0, s.spaces} + 13'd1);
    n.spaces = '0;
    n.dash   = 1'b0;
    n.phase  = ftc_pkg::PH_CONTENT;
    return n;
  endfunction

  always_comb begin
    ftc_pkg::lex_state_t s;
    ftc_pkg::cp_t        c;
    logic                done;
    logic                sep;
    s    = st;
    c    = item.code_point;
    done = 1'b0;
    sep  = st.mode == ftc_pkg::MODE_LEFT;
    k    = 2'd0;
    r[0] = '0;
    r[1] = '0;
    if (item.end_of_input) begin
      if (s.mode == ftc_pkg::MODE_TOP) begin
        if (s.phase == ftc_pkg::PH_COMMENT) begin
          r[k[0]] = '{ftc_pkg::K_COMMENT, s.count, 1'b0}; k = k + 2'd1;
        end else if (s.phase == ftc_pkg::PH_WORD) begin
          r[k[0]] = '{word_kind(s), s.count, 1'b0}; k = k + 2'd1;
        end else if (s.phase == ftc_pkg::PH_STRING) begin
          r[k[0]] = '{ftc_pkg::K_STRING, s.count, 1'b0}; k = k + 2'd1;
        end
        r[k[0]] = '{ftc_pkg::K_END, 12'd0, 1'b0}; k = k + 2'd1;
      end else begin
        if (s.dash) s = take_content(s);
        if (s.phase == ftc_pkg::PH_CONTENT) begin
          r[k[0]] = '{ftc_pkg::K_CONTENT, s.count, 1'b0}; k = k + 2'd1;
        end
        r[k[0]] = '{ftc_pkg::K_ERROR, 12'd0, 1'b0}; k = k + 2'd1;
      end
      s      = ftc_pkg::clear_token(s);
      s.mode = ftc_pkg::MODE_TOP;
    end else if (s.mode == ftc_pkg::MODE_TOP) begin
      case (s.phase)
        ftc_pkg::PH_COMMENT: begin
          if (ftc_pkg::is_ch(c, 8'h0a) || ftc_pkg::is_ch(c, 8'h0d)) begin
            r[k[0]] = '{ftc_pkg::K_COMMENT, s.count, 1'b0}; k = k + 2'd1;
            s = ftc_pkg::clear_token(s);
          end else s.count = ftc_pkg::sat_add(s.count, 13'd1);
        end
        ftc_pkg::PH_STRING: begin
          s.count = ftc_pkg::sat_add(s.count, 13'd1);
          if (ftc_pkg::is_ch(c, "\"")) begin
            r[k[0]] = '{ftc_pkg::K_STRING, s.count, 1'b0}; k = k + 2'd1;
            s = ftc_pkg::clear_token(s);
          end
        end
        ftc_pkg::PH_WORD: begin
          if (ftc_pkg::is_blank(c)) begin
            r[k[0]] = '{word_kind(s), s.count, 1'b0}; k = k + 2'd1;
            s = ftc_pkg::clear_token(s);
          end else s = feed_word(s, c);
        end
        default: begin
          if (!ftc_pkg::is_blank(c)) begin
            s = ftc_pkg::clear_token(s);
            if (ftc_pkg::is_ch(c, "\\")) begin
              s.phase = ftc_pkg::PH_COMMENT;
              s.count = 12'd1;
            end else if (ftc_pkg::is_ch(c, "(")) begin
              r[k[0]] = '{ftc_pkg::K_DELIM, 12'd1, 1'b0}; k = k + 2'd1;
              s.mode = ftc_pkg::MODE_LEFT;
            end else s = feed_word(s, c);
          end
        end
      endcase
    end else begin
      if (s.dash) begin
        s.dash = 1'b0;
        if (ftc_pkg::is_ch(c, "-")) begin
          if (s.phase == ftc_pkg::PH_CONTENT) begin
            r[k[0]] = '{ftc_pkg::K_CONTENT, s.count, 1'b0}; k = k + 2'd1;
          end
          r[k[0]] = '{ftc_pkg::K_SEP, 12'd2, 1'b0}; k = k + 2'd1;
          s      = ftc_pkg::clear_token(s);
          s.mode = ftc_pkg::MODE_RIGHT;
          done   = 1'b1;
        end else s = take_content(s);
      end
      if (!done && s.phase != ftc_pkg::PH_CONTENT && ftc_pkg::is_blank(c)) done = 1'b1;
      if (!done && s.depth == 4'd0 && ftc_pkg::is_ch(c, ")")) begin
        if (s.phase == ftc_pkg::PH_CONTENT) begin
          r[k[0]] = '{ftc_pkg::K_CONTENT, s.count, 1'b0}; k = k + 2'd1;
        end
        r[k[0]] = '{ftc_pkg::K_DELIM, 12'd1, 1'b0}; k = k + 2'd1;
        s      = ftc_pkg::clear_token(s);
        s.mode = ftc_pkg::MODE_TOP;
        done   = 1'b1;
      end
      if (!done && s.depth == 4'd0 && sep && ftc_pkg::is_ch(c, "-")) begin
        s.dash = 1'b1;
        done   = 1'b1;
      end
      if (!done) begin
        if (ftc_pkg::is_ch(c, "(")) begin
          if (s.depth < 4'(ftc_pkg::MaxNest)) s.depth = s.depth + 4'd1;
        end else if (ftc_pkg::is_ch(c, ")")) begin
          s.depth = s.depth - 4'd1;
        end else if (ftc_pkg::is_blank(c)) begin
          s.spaces = ftc_pkg::sat_add(s.spaces, 13'd1);
          done     = 1'b1;
        end
        if (!done) s = take_content(s);
      end
    end
    if (k == 2'd1) r[0].last_result = 1'b1;
    if (k == 2'd2) r[1].last_result = 1'b1;
    st_next = s;
  end

  assign nres = take ? k : 2'd0;
  assign res0 = r[0];
  assign res1 = r[1];

  // all-zero state is top mode, so clearing it gives the reset state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ftc_pkg::clear_token('0);
    end else if (take) begin
      st <= st_next;
    end
  end

endmodule

// ----- design/ftc_out_fifo.sv -----
// ----------------------------------------------------------------------------
// ftc_out_fifo
// Small result queue; takes up to two results per cycle, gives one per cycle unless out_stall holds it.
// ----------------------------------------------------------------------------
module ftc_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         npush,
  input  ftc_pkg::out_item_t din0,
  input  ftc_pkg::out_item_t din1,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output ftc_pkg::out_item_t out_item
);

  ftc_pkg::out_item_t mem [ftc_pkg::FifoDepth];
  logic [1:0]         wr_ptr;
  logic [1:0]         rd_ptr;
  logic [2:0]         count;
  logic               pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = count != 3'd0;
  assign out_item  = mem[rd_ptr];
  assign room      = count <= 3'(ftc_pkg::FifoDepth - 2);

  always_ff @(posedge clk) begin
    if (npush != 2'd0) mem[wr_ptr] <= din0;
    if (npush == 2'd2) mem[wr_ptr + 2'd1] <= din1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + npush;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, npush} - {2'b00, pop};
    end
  end

endmodule

// ----- design/forth_token_classifier_top.sv -----
// ----------------------------------------------------------------------------
// forth_token_classifier_top
// Streaming Forth tokenizer: one code point in, token kind and length out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_item) carries one code point or an
// end-of-input mark per word. Output channel (out_valid/out_stall/out_item)
// carries one token result per word; a character yields zero, one or two
// results, and last_result marks the final one for that character.
// Each accepted character updates the lexer state in the same edge; its
// results are written into a four-entry result queue that feeds out_item.
// Throughput is one character per cycle while the queue has room for two
// results; the queue drains one result per cycle while out_stall is low,
// so a run of two-result characters is paced by the output side.
// in_stall rises when fewer than two queue slots are free, i.e. whenever
// results back up behind a stalled receiver or two-result characters.
// Reset (rst, synchronous) empties the queue and puts the lexer in top
// mode between tokens.
// ----------------------------------------------------------------------------
module forth_token_classifier_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ftc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ftc_pkg::out_item_t out_item
);

  logic               take;
  logic               room;
  logic [1:0]         nres;
  ftc_pkg::out_item_t res0;
  ftc_pkg::out_item_t res1;

  assign in_stall = !room;
  assign take     = in_valid && room;

  ftc_lexer u_lexer (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (in_item),
    .nres (nres),
    .res0 (res0),
    .res1 (res1)
  );

  ftc_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .npush     (nres),
    .din0      (res0),
    .din1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- test/forth_token_classifier_top_test.sv -----
// ----------------------------------------------------------------------------
// forth_token_classifier_top_test
// Feeds Forth source (directed snippets, well-formed token streams and random
// noise) into the tokenizer and checks each token result against an internal
// lexer model, with random idling and a long output hold-off.
// ----------------------------------------------------------------------------
module forth_token_classifier_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ftc_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ftc_pkg::out_item_t out_item;

  forth_token_classifier_top u_dut (.*);

  always #4 clk = ~clk;

  ftc_pkg::in_item_t src_q[$];
  ftc_pkg::out_item_t tok_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit src_done = 0;
  bit calm = 0;
  int hold_left = 0;
  int hold_at = 400;

  // lexer model state
  ftc_pkg::mode_t    m_mode;
  ftc_pkg::phase_t   m_phase;
  int                m_count;
  ftc_pkg::num_t     m_num;
  int                m_op;
  int                m_depth;
  bit                m_dash;
  int                m_spaces;
  int                m_fc[3];
  bit                m_ascii;

  function automatic bit blank_c(int c);
    return c == 32 || (c >= 9 && c <= 13);
  endfunction

  function automatic bit dig(int c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int satl(int a, int b);
    return (a + b > ftc_pkg::LengthLimit) ? ftc_pkg::LengthLimit : a + b;
  endfunction

  function automatic ftc_pkg::num_t nbody(int c);
    if (c == "$") return ftc_pkg::N_HEXNEED;
    if (c == "%") return ftc_pkg::N_BINNEED;
    if (c == "&") return ftc_pkg::N_OCTNEED;
    if (c == "0") return ftc_pkg::N_ZERO;
    if (dig(c)) return ftc_pkg::N_INT;
    return ftc_pkg::N_REJ;
  endfunction

  function automatic ftc_pkg::num_t nnext(ftc_pkg::num_t s, int c);
    bit sg;
    bit ex;
    bit hx;
    sg = c == "+" || c == "-";
    ex = c == "e" || c == "E";
    hx = dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    case (s)
      ftc_pkg::N_START: return sg ? ftc_pkg::N_SIGN : nbody(c);
      ftc_pkg::N_SIGN: return nbody(c);
      ftc_pkg::N_HEXNEED, ftc_pkg::N_HEX: return hx ? ftc_pkg::N_HEX : ftc_pkg::N_REJ;
      ftc_pkg::N_BINNEED, ftc_pkg::N_BIN:
        return (c == "0" || c == "1") ? ftc_pkg::N_BIN : ftc_pkg::N_REJ;
      ftc_pkg::N_OCTNEED, ftc_pkg::N_OCT:
        return (c >= "0" && c <= "7") ? ftc_pkg::N_OCT : ftc_pkg::N_REJ;
      ftc_pkg::N_ZERO: begin
        if (c == "x" || c == "X") return ftc_pkg::N_HEXNEED;
        if (dig(c)) return ftc_pkg::N_INT;
        if (c == ".") return ftc_pkg::N_FRAC;
        return ex ? ftc_pkg::N_EXP : ftc_pkg::N_REJ;
      end
      ftc_pkg::N_INT: begin
        if (dig(c)) return ftc_pkg::N_INT;
        if (c == ".") return ftc_pkg::N_FRAC;
        return ex ? ftc_pkg::N_EXP : ftc_pkg::N_REJ;
      end
      ftc_pkg::N_FRAC: begin
        if (dig(c)) return ftc_pkg::N_FRAC;
        return ex ? ftc_pkg::N_EXP : ftc_pkg::N_REJ;
      end
      ftc_pkg::N_EXP: begin
        if (sg) return ftc_pkg::N_EXPSIGN;
        return dig(c) ? ftc_pkg::N_EXPDIG : ftc_pkg::N_REJ;
      end
      ftc_pkg::N_EXPSIGN, ftc_pkg::N_EXPDIG:
        return dig(c) ? ftc_pkg::N_EXPDIG : ftc_pkg::N_REJ;
      default: return ftc_pkg::N_REJ;
    endcase
  endfunction

  function automatic void reset_token();
    m_phase = ftc_pkg::PH_IDLE;
    m_count = 0;
    m_num = ftc_pkg::N_START;
    m_op = 0;
    m_depth = 0;
    m_dash = 0;
    m_spaces = 0;
    m_fc = '{0, 0, 0};
    m_ascii = 1;
  endfunction

  function automatic void emit(ftc_pkg::kind_t k, int len);
    ftc_pkg::out_item_t t;
    t.token_kind = k;
    t.token_length = ftc_pkg::len_t'(len);
    t.last_result = 1'b0;
    tok_q.push_back(t);
  endfunction

  function automatic void add_char(int c);
    int lc;
    int nx;
    bit hit;
    lc = (c >= "A" && c <= "Z") ? c + 32 : c;
    if (c > 127 || m_count >= ftc_pkg::MaxWord || m_count >= ftc_pkg::LengthLimit)
      m_ascii = 0;
    if (m_count < 3) m_fc[m_count] = c & 255;
    m_num = nnext(m_num, c);
    hit = 0;
    nx = ftc_pkg::OpDead;
    if ((m_op == 1 || m_op == 6) && c == "\"") hit = 1;
    else if (m_op == 0) begin
      if (c == "." || lc == "s" || lc == "c") nx = 1;
      else if (lc == "a") nx = 2;
    end else if (m_op == 2 && lc == "b") nx = 3;
    else if (m_op == 3 && lc == "o") nx = 4;
    else if (m_op == 4 && lc == "r") nx = 5;
    else if (m_op == 5 && lc == "t") nx = 6;
    m_op = nx;
    m_count = satl(m_count, 1);
    m_phase = hit ? ftc_pkg::PH_STRING : ftc_pkg::PH_WORD;
  endfunction

  function automatic ftc_pkg::kind_t word_class();
    if (m_ascii) begin
      if (m_count == 1 && m_fc[0] == ":") return ftc_pkg::K_COLON;
      if (m_count == 1 && m_fc[0] == ";") return ftc_pkg::K_SEMI;
      if (m_count == 3 && m_fc[0] == "'" && m_fc[2] == "'") return ftc_pkg::K_CHAR;
      if (m_num inside {ftc_pkg::N_ZERO, ftc_pkg::N_INT, ftc_pkg::N_FRAC,
                        ftc_pkg::N_EXPDIG, ftc_pkg::N_HEX, ftc_pkg::N_BIN,
                        ftc_pkg::N_OCT})
        return ftc_pkg::K_NUMBER;
    end
    return ftc_pkg::K_WORD;
  endfunction

  function automatic void absorb_content();
    m_count = satl(m_count, m_spaces + 1);
    m_spaces = 0;
    m_dash = 0;
    m_phase = ftc_pkg::PH_CONTENT;
  endfunction

  function automatic void lex_char(int c);
    if (m_mode == ftc_pkg::MODE_TOP) begin
      case (m_phase)
        ftc_pkg::PH_COMMENT:
          if (c == 10 || c == 13) begin
            emit(ftc_pkg::K_COMMENT, m_count);
            reset_token();
          end else m_count = satl(m_count, 1);
        ftc_pkg::PH_STRING: begin
          m_count = satl(m_count, 1);
          if (c == "\"") begin
            emit(ftc_pkg::K_STRING, m_count);
            reset_token();
          end
        end
        ftc_pkg::PH_WORD:
          if (blank_c(c)) begin
            emit(word_class(), m_count);
            reset_token();
          end else add_char(c);
        default:
          if (!blank_c(c)) begin
            reset_token();
            if (c == "\\") begin
              m_phase = ftc_pkg::PH_COMMENT;
              m_count = 1;
            end else if (c == "(") begin
              emit(ftc_pkg::K_DELIM, 1);
              m_mode = ftc_pkg::MODE_LEFT;
            end else add_char(c);
          end
      endcase
      return;
    end
    if (m_dash) begin
      m_dash = 0;
      if (c == "-") begin
        if (m_phase == ftc_pkg::PH_CONTENT) emit(ftc_pkg::K_CONTENT, m_count);
        emit(ftc_pkg::K_SEP, 2);
        reset_token();
        m_mode = ftc_pkg::MODE_RIGHT;
        return;
      end
      absorb_content();
    end
    if (m_phase != ftc_pkg::PH_CONTENT && blank_c(c)) return;
    if (m_depth == 0 && c == ")") begin
      if (m_phase == ftc_pkg::PH_CONTENT) emit(ftc_pkg::K_CONTENT, m_count);
      emit(ftc_pkg::K_DELIM, 1);
      reset_token();
      m_mode = ftc_pkg::MODE_TOP;
      return;
    end
    if (m_depth == 0 && m_mode == ftc_pkg::MODE_LEFT && c == "-") begin
      m_dash = 1;
      return;
    end
    if (c == "(") begin
      if (m_depth < ftc_pkg::MaxNest) m_depth++;
    end else if (c == ")") begin
      m_depth = (m_depth - 1) & 15;
    end else if (blank_c(c)) begin
      m_spaces = satl(m_spaces, 1);
      return;
    end
    absorb_content();
  endfunction

  function automatic void lex_end();
    if (m_mode == ftc_pkg::MODE_TOP) begin
      if (m_phase == ftc_pkg::PH_COMMENT) emit(ftc_pkg::K_COMMENT, m_count);
      else if (m_phase == ftc_pkg::PH_WORD) emit(word_class(), m_count);
      else if (m_phase == ftc_pkg::PH_STRING) emit(ftc_pkg::K_STRING, m_count);
      emit(ftc_pkg::K_END, 0);
    end else begin
      if (m_dash) absorb_content();
      if (m_phase == ftc_pkg::PH_CONTENT) emit(ftc_pkg::K_CONTENT, m_count);
      emit(ftc_pkg::K_ERROR, 0);
    end
    reset_token();
    m_mode = ftc_pkg::MODE_TOP;
  endfunction

  function automatic void predict(ftc_pkg::in_item_t it);
    int n0;
    n0 = tok_q.size();
    if (it.end_of_input) lex_end();
    else lex_char(int'(it.code_point));
    if (tok_q.size() > n0) tok_q[tok_q.size() - 1].last_result = 1'b1;
  endfunction

  // stimulus helpers
  function automatic void put_c(int c);
    ftc_pkg::in_item_t it;
    it.code_point = ftc_pkg::cp_t'(c);
    it.end_of_input = 1'b0;
    src_q.push_back(it);
  endfunction

  function automatic void put_s(string s);
    foreach (s[i]) put_c(s[i]);
  endfunction

  function automatic void put_eoi();
    ftc_pkg::in_item_t it;
    it.code_point = ftc_pkg::cp_t'($urandom);
    it.end_of_input = 1'b1;
    src_q.push_back(it);
  endfunction

  function automatic void put_ws();
    int ws[6] = '{32, 9, 10, 13, 12, 11};
    put_c(($urandom_range(0, 3) == 0) ? ws[$urandom_range(0, 5)] : 32);
  endfunction

  function automatic void put_piece();
    string lib[] = '{"." , "s\"", "C\"", "AbOrT\"", ":", ";", "'a'", "-12.5e+3", "$fF",
                     "%101", "&17", "0x1A", "0X", "+7", "1e", "dup", "swap", "--",
                     "0.", "+", "&8", "%2", "''x'"};
    case ($urandom_range(0, 9))
      0: begin
        put_s("s\" ");
        repeat ($urandom_range(0, 6)) put_c($urandom_range(32, 126) == 34 ? 65 : 66);
        put_c(34);
      end
      1: begin
        put_c("\\");
        repeat ($urandom_range(0, 5)) put_c($urandom_range(32, 126));
        put_c($urandom_range(0, 1) ? 10 : 13);
      end
      2: begin
        put_c("(");
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 5))
            0: put_c(32);
            1: put_c("-");
            2: put_c("(");
            3: put_c(")");
            default: put_c($urandom_range(97, 122));
          endcase
        end
        if ($urandom_range(0, 2) != 0) put_s(" -- ");
        repeat ($urandom_range(0, 4)) put_c($urandom_range(0, 1) ? 32 : "x");
        put_c(")");
      end
      3: repeat ($urandom_range(1, 6)) put_c($urandom_range(33, 126));
      4: put_c($urandom_range(0, 1) ? $urandom_range(128, 1114111) : $urandom);
      default: put_s(lib[$urandom_range(0, lib.size() - 1)]);
    endcase
    put_ws();
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict(in_item);
      if (src_q.size() > 0 && (calm || $urandom_range(0, 99) >= 33)) begin
        in_item <= src_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_at == 0) begin
      hold_at <= -1;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else begin
      if (hold_at > 0) hold_at <= hold_at - 1;
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 33);
    end
  end

  // monitor
  always @(posedge clk) begin
    ftc_pkg::out_item_t exp_t;
    if (!rst && out_valid && !out_stall) begin
      if (tok_q.size() == 0) begin
        $display("%0t unexpected token: expected none, actual %h", $time, out_item);
        errors++;
      end else begin
        exp_t = tok_q.pop_front();
        if (out_item.token_kind !== exp_t.token_kind ||
            out_item.token_length !== exp_t.token_length ||
            out_item.last_result !== exp_t.last_result) begin
          $display("%0t mismatch: expected kind %0d len %0d last %0d, actual kind %0d len %0d last %0d",
                   $time, exp_t.token_kind, exp_t.token_length, exp_t.last_result,
                   out_item.token_kind, out_item.token_length, out_item.last_result);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst ||
        (src_done && tok_q.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    m_mode = ftc_pkg::MODE_TOP;
    reset_token();
    put_s(": sq dup * ; ");
    put_s("\\ c\n( a (b) - c -- d )");
    put_s(" 'q' -1.5E-2 $Ff %10 &7 0x9 x9 ");
    put_c(1114111); put_c(2097151); put_c(0); put_eoi();
    put_s("(  ab  "); put_eoi();
    put_s("Abort\" hi\""); put_eoi();
    repeat (16) put_c("(");
    put_s(")))");
    put_eoi();
    repeat (300) put_c("w");
    put_c(32);
    put_eoi();
    while (src_q.size() < 1340) begin
      put_piece();
      if ($urandom_range(0, 40) == 0) put_eoi();
    end
    put_eoi();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (src_q.size() < 900);
    calm = 1;
    wait (src_q.size() < 500);
    calm = 0;
    wait (src_q.size() == 0 && !in_valid);
    src_done = 1;
    wait (tok_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && tok_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ----- files.f -----
design/ftc_pkg.sv
design/ftc_lexer.sv
design/ftc_out_fifo.sv
design/forth_token_classifier_top.sv
test/forth_token_classifier_top_test.sv
